/* hdl/rclfr_pkg.sv */
// ----------------------------------------------------------------------------
// rclfr_pkg
// Shared constants and types of the RC link frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package rclfr_pkg;

    localparam int MAX_FRAME_BYTES       = 64;
    localparam int CHANNEL_PAYLOAD_BYTES = 22;

    localparam int NUM_CH      = 6;
    localparam int CH_BITS     = 11;
    localparam int SHADOW_BITS = NUM_CH * CH_BITS;
    localparam int CNT_W       = $clog2(MAX_FRAME_BYTES);
    localparam int PWM_W       = 11;

    // Pulse width of a centered channel, the value after reset.
    localparam logic [PWM_W-1:0] PWM_CENTER = PWM_W'(1500);

    localparam logic [7:0]  SYNC_RESET    = 8'd200;
    localparam logic [7:0]  TYPE_RESET    = 8'd22;
    localparam logic [15:0] TIMEOUT_RESET = 16'd500;

    // Configuration register indexes.
    localparam logic [1:0] REG_SYNC_VALUE   = 2'd0;
    localparam logic [1:0] REG_FRAME_TYPE   = 2'd1;
    localparam logic [1:0] REG_TIMEOUT      = 2'd2;

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_LENGTH,
        ST_BODY
    } t_rx_state;

    typedef struct packed {
        logic done;
        logic accepted;
    } t_frame_evt;

    typedef logic [SHADOW_BITS-1:0]            t_shadow;
    typedef logic [NUM_CH-1:0][PWM_W-1:0]      t_pwm_arr;

endpackage

`default_nettype wire

/* hdl/rclfr_frame.sv */
// ----------------------------------------------------------------------------
// rclfr_frame
// Frame parser: sync hunt, length check, CRC-8 and channel unpacking.
// ----------------------------------------------------------------------------
`default_nettype none

module rclfr_frame
    import rclfr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic       i_op,
    input  wire logic [7:0] i_byte,
    input  wire logic [7:0] i_sync_value,
    input  wire logic [7:0] i_frame_type,
    output t_frame_evt      o_evt,
    output t_shadow         o_shadow
);

    localparam logic [7:0] LEN_MIN    = 8'd2;
    localparam logic [7:0] LEN_MAX    = 8'(MAX_FRAME_BYTES - 2);
    localparam logic [8:0] LEN_ACCEPT = 9'(CHANNEL_PAYLOAD_BYTES + 2);

    t_rx_state        r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_crc, n_crc;
    t_shadow          r_shadow, n_shadow;

    logic             byte_step;
    logic             crc_byte;
    logic             len_bad;
    logic [CNT_W-1:0] pos;

    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = (c << 1) ^ 8'hD5;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

    assign byte_step = i_step && !i_op;
    assign crc_byte  = {{(9-CNT_W){1'b0}}, r_cnt} >= ({1'b0, r_len} + 9'd1);
    assign len_bad   = (i_byte < LEN_MIN) || (i_byte > LEN_MAX);
    assign pos       = r_cnt - CNT_W'(3);

    // Next state.
    always_comb begin
        n_state = r_state;
        if (byte_step) begin
            case (r_state)
                ST_HUNT: begin
                    if (i_byte == i_sync_value) begin
                        n_state = ST_LENGTH;
                    end
                end
                ST_LENGTH: begin
                    n_state = len_bad ? ST_HUNT : ST_BODY;
                end
                ST_BODY: begin
                    if (crc_byte) begin
                        n_state = ST_HUNT;
                    end
                end
                default: begin
                    n_state = ST_HUNT;
                end
            endcase
        end
    end

    // Datapath and frame result.
    always_comb begin
        n_cnt        = r_cnt;
        n_len        = r_len;
        n_type       = r_type;
        n_crc        = r_crc;
        n_shadow     = r_shadow;
        o_evt        = '0;
        if (byte_step) begin
            case (r_state)
                ST_HUNT: begin
                    n_cnt = CNT_W'(1);
                end
                ST_LENGTH: begin
                    n_len = i_byte;
                    n_crc = 8'd0;
                    n_cnt = CNT_W'(2);
                end
                ST_BODY: begin
                    if (crc_byte) begin
                        o_evt.done     = 1'b1;
                        o_evt.accepted = (i_byte == r_crc) && (r_type == i_frame_type)
                                         && ({1'b0, r_len} >= LEN_ACCEPT);
                        n_cnt          = '0;
                    end else begin
                        if (r_cnt == CNT_W'(2)) begin
                            n_type = i_byte;
                        end else begin
                            // Channel bits are packed LSB-first across the payload.
                            for (int k = 0; k < SHADOW_BITS; k++) begin
                                if (pos == CNT_W'(k / 8)) begin
                                    n_shadow[k] = i_byte[k % 8];
                                end
                            end
                        end
                        n_crc = crc_step(r_crc, i_byte);
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
                default: begin
                    n_cnt = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
            r_cnt   <= '0;
            r_len   <= '0;
            r_type  <= '0;
            r_crc   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_len   <= n_len;
            r_type  <= n_type;
            r_crc   <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shadow <= n_shadow;
    end

    assign o_shadow = r_shadow;

endmodule

`default_nettype wire

/* hdl/rclfr_status.sv */
// ----------------------------------------------------------------------------
// rclfr_status
// Committed pulse widths, tick counter and signal-present flag.
// ----------------------------------------------------------------------------
`default_nettype none

module rclfr_status
    import rclfr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire logic        i_op,
    input  wire t_frame_evt  i_evt,
    input  wire t_shadow     i_shadow,
    input  wire logic [15:0] i_timeout,
    output logic             o_link_ok,
    output t_pwm_arr         o_pwm
);

    localparam logic [21:0] PWM_SCALE  = 22'd1000;
    localparam logic [21:0] PWM_OFFSET = 22'd512000;
    localparam logic [11:0] PWM_MIN    = 12'd1000;
    localparam logic [11:0] PWM_MAX    = 12'd2000;

    logic [15:0] r_ticks, n_ticks;
    logic        r_flag, n_flag;
    t_pwm_arr    r_pwm, n_pwm;
    t_pwm_arr    shadow_pwm;

    function automatic logic [PWM_W-1:0] to_pwm(input logic [CH_BITS-1:0] raw);
        logic [21:0] scaled;
        logic [11:0] p;
        scaled = {{(22-CH_BITS){1'b0}}, raw} * PWM_SCALE + PWM_OFFSET;
        p      = scaled[21:10];
        if (p < PWM_MIN) begin
            p = PWM_MIN;
        end
        if (p > PWM_MAX) begin
            p = PWM_MAX;
        end
        return p[PWM_W-1:0];
    endfunction

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            shadow_pwm[c] = to_pwm(i_shadow[c*CH_BITS +: CH_BITS]);
        end
    end

    always_comb begin
        n_ticks = r_ticks;
        n_flag  = r_flag;
        n_pwm   = r_pwm;
        if (i_step) begin
            if (i_op) begin
                if (r_ticks != 16'hFFFF) begin
                    n_ticks = r_ticks + 16'd1;
                end
                if (n_ticks > i_timeout) begin
                    n_flag = 1'b0;
                end
            end else if (i_evt.accepted) begin
                n_ticks = '0;
                n_flag  = 1'b1;
                n_pwm   = shadow_pwm;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= '0;
            r_flag  <= 1'b0;
            r_pwm   <= {NUM_CH{PWM_CENTER}};
        end else begin
            r_ticks <= n_ticks;
            r_flag  <= n_flag;
            r_pwm   <= n_pwm;
        end
    end

    // The values after this item, for the result register.
    assign o_link_ok = n_flag;
    assign o_pwm     = n_pwm;

endmodule

`default_nettype wire

/* hdl/rc_link_frame_receiver.sv */
// ----------------------------------------------------------------------------
// rc_link_frame_receiver
// Parses RC channel link frames from a byte stream and tracks link health.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// s_axis    in   tdata: rx_byte[7:0]; tuser: operation[0]
// m_axis    out  tdata: frame_done, frame_accepted, link_ok, six 11-bit pulses
// cfg       in   i_cfg_index[1:0], i_cfg_data[15:0]
//
// One item per cycle while the result side does not stall. A transaction is
// held in the input register while the parser and status logic work on it;
// its result is registered in the output register, from which it leaves.
// The input register accepts a new transaction while the result is stalled
// as long as it is empty; ready drops only when both registers are full
// and the result side stalls.
// Reset is synchronous; channels come up centered at 1500 us, link down.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_link_frame_receiver
    import rclfr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
    input  wire logic        s_axis_tuser,   // operation[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // frame_done[0], frame_accepted[1], link_ok[2], pulse_throttle[13:3],
    // pulse_roll[24:14], pulse_pitch[35:25], pulse_yaw[46:36],
    // pulse_mode[57:47], pulse_aux[68:58], zero fill[71:69]
    output logic [71:0]      m_axis_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    logic        r_in_valid;
    logic        r_in_op;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    logic [71:0] r_out_data;

    logic [7:0]  r_sync_value;
    logic [7:0]  r_frame_type;
    logic [15:0] r_timeout;

    logic        advance;
    logic        step;
    t_frame_evt  evt;
    t_shadow     shadow;
    logic        link_ok;
    t_pwm_arr    pwm;

    assign advance       = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_value <= SYNC_RESET;
            r_frame_type <= TYPE_RESET;
            r_timeout    <= TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SYNC_VALUE: r_sync_value <= i_cfg_data[7:0];
                REG_FRAME_TYPE: r_frame_type <= i_cfg_data[7:0];
                REG_TIMEOUT:    r_timeout    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op   <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    rclfr_frame u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_op         (r_in_op),
        .i_byte       (r_in_byte),
        .i_sync_value (r_sync_value),
        .i_frame_type (r_frame_type),
        .o_evt        (evt),
        .o_shadow     (shadow)
    );

    rclfr_status u_status (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_op      (r_in_op),
        .i_evt     (evt),
        .i_shadow  (shadow),
        .i_timeout (r_timeout),
        .o_link_ok (link_ok),
        .o_pwm     (pwm)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= {3'b000, pwm, link_ok, evt.accepted, evt.done};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire
